// ===== sv/audio_resample_gain_mute_macros.svh =====
// Assertion macros shared by the checker of the resampler.
`ifndef AUDIO_RESAMPLE_GAIN_MUTE_MACROS_SVH
`define AUDIO_RESAMPLE_GAIN_MUTE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ARGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ARGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define ARGM_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/argm_pkg.sv =====
// Package with constants, types and the gain function of the resampler.
`timescale 1ns / 1ps

package argm_pkg;

  localparam int OUTPUT_RATE     = 48000;
  localparam int GAIN_SHIFT      = 2;
  localparam int MAX_RESULTS     = 64;
  localparam int MIN_SRC_RATE    = 750;
  localparam int SRC_RESET       = 48000;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 18;
  localparam int ACC_W     = RATE_W + 1;
  localparam int CNT_W     = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W = 2;
  localparam int WIDE_W    = SAMPLE_W + GAIN_SHIFT;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MUTE     = CFG_IDX_W'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic drop;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_ge;
    logic step_last;
    logic out_free;
  } sts_t;

  // Shift left by the gain and saturate to the sample width.
  function automatic logic [SAMPLE_W-1:0] gain_sat(input logic signed [SAMPLE_W-1:0] s);
    logic signed [WIDE_W-1:0] v;
    logic signed [WIDE_W-1:0] max_v;
    logic signed [WIDE_W-1:0] min_v;
    logic [SAMPLE_W-1:0]      r;
    v     = WIDE_W'(s) <<< GAIN_SHIFT;
    max_v = WIDE_W'(2 ** (SAMPLE_W - 1) - 1);
    min_v = -WIDE_W'(2 ** (SAMPLE_W - 1));
    if (v > max_v) begin
      r = max_v[SAMPLE_W-1:0];
    end else if (v < min_v) begin
      r = min_v[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/argm_ctrl.sv =====
// Controller state machine of the resampler.
`timescale 1ns / 1ps

module argm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  argm_pkg::sts_t  sts,
  output argm_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.acc_ge) begin
          // no frame due: store the phase and drop the item
          cmd.drop   = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/argm_dp.sv =====
// Datapath of the resampler: registers, phase accumulator and output stage.
`timescale 1ns / 1ps

module argm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [argm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [argm_pkg::RATE_W-1:0]            cfg_data,
  input  logic [2*argm_pkg::SAMPLE_W-1:0]        in_data,
  input  argm_pkg::cmd_t                         cmd,
  output argm_pkg::sts_t                         sts,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2*argm_pkg::SAMPLE_W-1:0]        out_data,
  output logic                                   out_last
);

  logic [argm_pkg::RATE_W-1:0]   src_rate;
  logic                          mute;
  logic [argm_pkg::RATE_W-1:0]   phase;
  logic [argm_pkg::ACC_W-1:0]    acc;
  logic [argm_pkg::CNT_W-1:0]    cnt;
  logic [argm_pkg::SAMPLE_W-1:0] smp_left;
  logic [argm_pkg::SAMPLE_W-1:0] smp_right;

  logic [argm_pkg::RATE_W-1:0]   src_eff;
  logic [argm_pkg::ACC_W-1:0]    src_wide;
  logic [argm_pkg::ACC_W-1:0]    sub;
  logic                          sub_ge;

  assign src_eff  = (src_rate < argm_pkg::RATE_W'(argm_pkg::MIN_SRC_RATE))
                  ? argm_pkg::RATE_W'(argm_pkg::MIN_SRC_RATE) : src_rate;
  assign src_wide = {1'b0, src_eff};
  assign sub      = acc - src_wide;
  assign sub_ge   = (sub >= src_wide);

  assign sts.acc_ge    = (acc >= src_wide);
  assign sts.step_last = !sub_ge || (cnt == argm_pkg::CNT_W'(argm_pkg::MAX_RESULTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rate <= argm_pkg::RATE_W'(argm_pkg::SRC_RESET);
      mute     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == argm_pkg::REG_SRC_RATE) begin
        src_rate <= cfg_data;
      end else if (cfg_index == argm_pkg::REG_MUTE) begin
        mute <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cfg_we && (cfg_index == argm_pkg::REG_SRC_RATE)) begin
      phase <= '0;
    end else if (cmd.drop) begin
      phase <= acc[argm_pkg::RATE_W-1:0];
    end else if (cmd.step && sts.step_last) begin
      // saturate when the run was cut at the frame limit
      phase <= sub_ge ? (src_eff - argm_pkg::RATE_W'(1)) : sub[argm_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= {1'b0, phase} + argm_pkg::ACC_W'(argm_pkg::OUTPUT_RATE);
      cnt <= '0;
      if (mute) begin
        smp_left  <= '0;
        smp_right <= '0;
      end else begin
        smp_left  <= argm_pkg::gain_sat(in_data[argm_pkg::SAMPLE_W-1:0]);
        smp_right <= argm_pkg::gain_sat(in_data[2*argm_pkg::SAMPLE_W-1:argm_pkg::SAMPLE_W]);
      end
    end else if (cmd.step) begin
      acc <= sub;
      cnt <= cnt + argm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data <= {smp_right, smp_left};
      out_last <= sts.step_last;
    end
  end

endmodule

// ===== sv/audio_resample_gain_mute.sv =====
// Top level of the zero-order-hold resampler with gain and mute.
//
//   channel   direction  signals                       payload
//   s_axis    in         tvalid tready tdata[31:0]     in_left, in_right
//   m_axis    out        tvalid tready tdata tlast     out_left, out_right; tlast = run_last
//   cfg       in         valid ready index data        0 input rate, 1 mute
//
// An input frame is taken in S_IDLE; then S_RUN emits one frame per cycle (up to 64)
// while m_axis is not stalled, each advancing the phase accumulator by one subtract;
// an item that emits no frame ends with a drop step in S_RUN.
// The output register lets the next input be taken while the last frame waits.
// Synchronous reset sets the input rate to 48000, mute 0, phase 0. A stalled
// m_axis holds the run until the frame is taken.
`timescale 1ns / 1ps

module audio_resample_gain_mute (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*argm_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // in_left, in_right
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [2*argm_pkg::SAMPLE_W-1:0]     m_axis_tdata,   // out_left, out_right
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [argm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [argm_pkg::RATE_W-1:0]         cfg_data
);

  argm_pkg::cmd_t cmd;
  argm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  argm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  argm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== sv/argm_checker.sv =====
// Port-level checker of the resampler, bound to the top level.
`timescale 1ns / 1ps
`include "audio_resample_gain_mute_macros.svh"

module argm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [2*argm_pkg::SAMPLE_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  `ARGM_ASSERT_NEXT_RST(a_rst_no_out, rst, !m_axis_tvalid, "output valid after reset")
  `ARGM_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  `ARGM_ASSERT_NOW(a_run_blocks_in, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready inside a run")
  `ARGM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

endmodule

bind audio_resample_gain_mute argm_checker u_argm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the zero-order-hold resampler with gain and mute.
`timescale 1ns / 1ps

module testbench;
  import argm_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int IDLE_PCT      = 21;
  localparam int DIR_ROWS      = 33;
  localparam int RAND_PHASES   = 8;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECK
  } row_kind_t;

  // ROW_CHECK rows carry the frame and count read off directly; ROW_ITEM rows
  // are predicted.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [RATE_W-1:0]     val;
    logic [SAMPLE_W-1:0]   left;
    logic [SAMPLE_W-1:0]   right;
    logic [SAMPLE_W-1:0]   exp_left;
    logic [SAMPLE_W-1:0]   exp_right;
    logic [6:0]            exp_count;
  } dir_row_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              mute;
    logic [7:0]        count;
    logic              quiet;
  } rand_phase_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
  } frame_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata;   // in_left, in_right
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;   // out_left, out_right
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [RATE_W-1:0]     cfg_data;

  audio_resample_gain_mute uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor state, kept in step with the register writes and input transfers.
  int unsigned rate_q;
  bit          mute_q;
  int unsigned phase_q;

  frame_t pending_frames[$];

  int mismatches;
  int frames_sent;
  int frames_out;
  int reg_writes;
  int longest_run;
  int s_idle_pct;
  int m_idle_pct;
  int cycle_count;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_CHECK, '0, '0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd1},
    '{ROW_CHECK, '0, '0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 7'd1},
    '{ROW_CHECK, '0, '0, 16'h1fff, 16'he000, 16'h7ffc, 16'h8000, 7'd1},
    '{ROW_CHECK, '0, '0, 16'hdfff, 16'h2000, 16'h8000, 16'h7fff, 7'd1},
    '{ROW_CHECK, '0, '0, 16'h0001, 16'hffff, 16'h0004, 16'hfffc, 7'd1},
    '{ROW_ITEM,  '0, '0, 16'h5555, 16'haaaa, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CFG, REG_MUTE, 18'd1, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 7'd1},
    '{ROW_CFG, REG_MUTE, 18'd0, '0, '0, '0, '0, '0},
    // lowest legal rate: 64 frames per input
    '{ROW_CFG, REG_SRC_RATE, 18'd750, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h0064, 16'hff9c, 16'h0190, 16'hfe70, 7'd64},
    // rates below the floor act as 750
    '{ROW_CFG, REG_SRC_RATE, 18'd0, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'hffff, 16'h0001, 16'hfffc, 16'h0004, 7'd64},
    '{ROW_CFG, REG_SRC_RATE, 18'd749, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h0007, 16'h0007, 16'h001c, 16'h001c, 7'd64},
    // rate 192000: one frame every fourth input
    '{ROW_CFG, REG_SRC_RATE, 18'd192000, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h1234, 16'h4321, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CHECK, '0, '0, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CHECK, '0, '0, 16'haaaa, 16'h5555, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CHECK, '0, '0, 16'h0123, 16'hfedc, 16'h048c, 16'hfb70, 7'd1},
    '{ROW_CFG, REG_SRC_RATE, 18'h3ffff, '0, '0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 7'd0},
    '{ROW_ITEM,  '0, '0, 16'h8000, 16'hffff, 16'h0000, 16'h0000, 7'd0},
    '{ROW_ITEM,  '0, '0, 16'h3c3c, 16'hc3c3, 16'h0000, 16'h0000, 7'd0},
    // rewriting the same rate must still clear the phase
    '{ROW_CFG, REG_SRC_RATE, 18'd96000, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CFG, REG_SRC_RATE, 18'd96000, '0, '0, '0, '0, '0},
    '{ROW_CHECK, '0, '0, 16'h0300, 16'h0400, 16'h0000, 16'h0000, 7'd0},
    '{ROW_CHECK, '0, '0, 16'h0010, 16'hfff0, 16'h0040, 16'hffc0, 7'd1},
    '{ROW_CFG, REG_SRC_RATE, 18'd44100, '0, '0, '0, '0, '0},
    '{ROW_ITEM,  '0, '0, 16'h0fff, 16'hf001, 16'h0000, 16'h0000, 7'd0},
    '{ROW_ITEM,  '0, '0, 16'h4000, 16'hc000, 16'h0000, 16'h0000, 7'd0},
    '{ROW_ITEM,  '0, '0, 16'h0abc, 16'hf543, 16'h0000, 16'h0000, 7'd0}
  };

  rand_phase_t rand_phases [RAND_PHASES] = '{
    '{18'd48000,  1'b0, 8'd15, 1'b0},
    '{18'd44100,  1'b0, 8'd20, 1'b1},
    '{18'd750,    1'b0, 8'd5,  1'b0},
    '{18'd192000, 1'b0, 8'd20, 1'b0},
    '{18'h3ffff,  1'b1, 8'd12, 1'b0},
    '{18'd0,      1'b1, 8'd3,  1'b0},
    '{18'd48000,  1'b0, 8'd20, 1'b0},
    '{18'd32000,  1'b1, 8'd15, 1'b0}
  };

  function automatic logic [SAMPLE_W-1:0] amplify(input logic signed [SAMPLE_W-1:0] s);
    int v;
    v = int'(s) * (1 << GAIN_SHIFT);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  // Advance the phase by one input frame; return how many output frames it emits.
  task automatic advance_phase(output int n);
    int unsigned src;
    int unsigned acc;
    src = (rate_q < MIN_SRC_RATE) ? MIN_SRC_RATE : rate_q;
    acc = phase_q + OUTPUT_RATE;
    n = 0;
    while (acc >= src && n < MAX_RESULTS) begin
      acc -= src;
      n++;
    end
    if (acc >= src) acc = src - 1;
    phase_q = acc;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 3))
      0: s = SAMPLE_W'($urandom);
      1: s = SAMPLE_W'(int'($urandom_range(0, 16383)) - 8192);
      2: begin
        case ($urandom_range(0, 7))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'hffff;
          4: s = 16'h1fff;
          5: s = 16'he000;
          6: s = 16'h2000;
          default: s = 16'hdfff;
        endcase
      end
      default: s = SAMPLE_W'(int'($urandom_range(8180, 8200)) * ($urandom_range(0, 1) ? 1 : -1));
    endcase
    return s;
  endfunction

  // Drop valids, wait for every pending frame, then let the block go quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    cfg_valid     <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SRC_RATE) begin
      rate_q  = val;
      phase_q = 0;
    end else if (idx == REG_MUTE) begin
      mute_q = val[0];
    end
    reg_writes++;
  endtask

  // Send one stereo frame; on transfer, queue the frames it must produce.
  task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                            input bit typed, input logic [SAMPLE_W-1:0] el,
                            input logic [SAMPLE_W-1:0] er, input int en);
    int     n;
    frame_t f;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    do @(posedge clk); while (!s_axis_tready);
    frames_sent++;
    advance_phase(n);
    if (typed) begin
      n       = en;
      f.left  = el;
      f.right = er;
    end else begin
      f.left  = mute_q ? '0 : amplify(l);
      f.right = mute_q ? '0 : amplify(r);
    end
    if (n > longest_run) longest_run = n;
    for (int i = 0; i < n; i++) begin
      f.last = (i == n - 1);
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames outstanding",
               cycle_count, pending_frames.size());
      $display("audio_resample_gain_mute regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= m_idle_pct);
  end

  always @(posedge clk) begin
    frame_t want;
    frame_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.left  = m_axis_tdata[SAMPLE_W-1:0];
      got.right = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
      got.last  = m_axis_tlast;
      frames_out++;
      if (pending_frames.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output frame left %h right %h last %b",
                   got.left, got.right, got.last);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("output frame %0d: expected left %h right %h last %b, got %h %h %b",
                     frames_out, want.left, want.right, want.last,
                     got.left, got.right, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    frames_sent   = 0;
    frames_out    = 0;
    reg_writes    = 0;
    longest_run   = 0;
    cycle_count   = 0;
    s_idle_pct    = IDLE_PCT;
    m_idle_pct    = IDLE_PCT;
    rate_q        = SRC_RESET;
    mute_q        = 1'b0;
    phase_q       = 0;

    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG:   write_reg(row.idx, row.val);
        ROW_CHECK: send_frame(row.left, row.right, 1'b1, row.exp_left, row.exp_right,
                              row.exp_count);
        default:   send_frame(row.left, row.right, 1'b0, '0, '0, 0);
      endcase
    end

    rand_phases[6].rate = RATE_W'($urandom_range(8000, 96000));
    rand_phases[6].mute = 1'($urandom_range(0, 1));
    foreach (rand_phases[p]) begin
      write_reg(REG_SRC_RATE, rand_phases[p].rate);
      write_reg(REG_MUTE, RATE_W'(rand_phases[p].mute));
      s_idle_pct = rand_phases[p].quiet ? 0 : IDLE_PCT;
      m_idle_pct = rand_phases[p].quiet ? 0 : IDLE_PCT;
      for (int k = 0; k < rand_phases[p].count; k++) begin
        // hold the sender now and then until the output has caught up
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_frame(random_sample(), random_sample(), 1'b0, '0, '0, 0);
      end
    end

    wait_idle();
    $display("sent %0d input frames and checked %0d output frames after %0d register writes",
             frames_sent, frames_out, reg_writes);
    $display("rates 0 to 262143 incl. the 750 floor, mute on and off, runs of 0 to %0d frames",
             longest_run);
    if (mismatches == 0) begin
      $display("audio_resample_gain_mute regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("audio_resample_gain_mute regression: fail");
    end
    $finish;
  end

endmodule

// ===== audio_resample_gain_mute.f =====
+incdir+sv
sv/argm_pkg.sv
sv/argm_ctrl.sv
sv/argm_dp.sv
sv/audio_resample_gain_mute.sv
sv/argm_checker.sv
tb/testbench.sv
